// ===== rtl/mts_pkg.sv =====
// Shared types, constants and helpers for the magnetic track steering block.
`default_nettype none

package mts_pkg;

  // Sensor array
  localparam int SENSOR_COUNT    = 6;
  localparam int SENSOR_BITS_DEF = 8;
  localparam int IDX_W           = 3;

  // Sensor positions, left outer to right outer
  localparam logic [IDX_W-1:0] SEN_OUT_L = 3'd0;
  localparam logic [IDX_W-1:0] SEN_MID_L = 3'd1;
  localparam logic [IDX_W-1:0] SEN_CEN_L = 3'd2;
  localparam logic [IDX_W-1:0] SEN_CEN_R = 3'd3;
  localparam logic [IDX_W-1:0] SEN_MID_R = 3'd4;
  localparam logic [IDX_W-1:0] SEN_OUT_R = 3'd5;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_STEER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_LVL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LOST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LOST   = 3'd6;

  // Register widths and reset values
  localparam int GAIN_W  = 6;
  localparam int LIMIT_W = 9;
  localparam int LEVEL_W = 8;
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 6'd8;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 6'd21;
  localparam logic [LIMIT_W-1:0] RST_STEER_LIM  = 9'd280;
  localparam logic [LIMIT_W-1:0] RST_LOST_STEER = 9'd300;
  localparam logic [LEVEL_W-1:0] RST_OUTER_LVL  = 8'd50;
  localparam logic [LEVEL_W-1:0] RST_INNER_LOST = 8'd30;
  localparam logic [LEVEL_W-1:0] RST_MID_LOST   = 8'd60;

  // Datapath widths
  localparam int ERR_W   = 11;
  localparam int STEER_W = 10;
  localparam int PP_W    = ERR_W + GAIN_W + 1;      // err * prop gain
  localparam int PDF_W   = ERR_W + 1 + GAIN_W + 1;  // delta err * deriv gain
  localparam int PD_W    = PDF_W + 1;
  localparam int GP_W    = 8;                       // gain product, hundredths
  localparam int X_W     = PD_W + GP_W + 1;
  localparam int CAP_W   = 19;

  // Error saturation bounds
  localparam int ERR_POS_MAX = 1023;
  localparam int ERR_NEG_MAG = 1024;

  // Divide by ten: q ~= (m * 26214) >> 18, low by at most one
  localparam int                RECIP10_W     = 15;
  localparam logic [RECIP10_W-1:0] RECIP10    = 15'd26214;
  localparam int                RECIP10_SHIFT = 18;
  localparam int                TEN           = 10;

  // Divide by thousand: q ~= (m * 268435) >> 28, low by at most one
  localparam logic [CAP_W-1:0] RECIP1000     = 19'd268435;
  localparam int               RECIP1000_SHIFT = 28;
  localparam int               THOUSAND      = 1000;
  localparam logic [CAP_W-1:0] CAP_MAX       = 19'd511999;

  // Gain factors in tenths
  localparam logic [3:0] F_CENTER = 4'd2;
  localparam logic [3:0] F_CUT    = 4'd3;
  localparam logic [3:0] F_UNIT   = 4'd10;
  localparam logic [3:0] F_BOOST  = 4'd12;
  localparam logic [3:0] F_NEAR   = 4'd13;
  localparam logic [3:0] F_WIDE   = 4'd14;
  localparam int         NEAR_MARGIN = 15;

  // Remembered side
  localparam logic [1:0] SIDE_NONE = 2'b00;
  localparam logic [1:0] SIDE_POS  = 2'b01;
  localparam logic [1:0] SIDE_NEG  = 2'b11;

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             scan_en;
    logic [IDX_W-1:0] scan_idx;
    logic             err_num;
    logic             err_mul;
    logic             err_fix;
    logic             pd_mul;
    logic             pd_sum;
    logic             gain;
    logic             st_mul;
    logic             div_mul;
    logic             finish;
  } mts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } mts_sts_t;

  // Pattern factor from the top-two sensor pair
  function automatic logic [3:0] pattern_factor(input logic [IDX_W-1:0] top,
                                                input logic [IDX_W-1:0] sec,
                                                input logic             near21,
                                                input logic             near34);
    logic [3:0] f;
    f = F_UNIT;
    case (top)
      SEN_MID_L: begin
        if (sec == SEN_CEN_L) f = F_BOOST;
        else if (sec == SEN_OUT_L) f = F_WIDE;
      end
      SEN_CEN_L: begin
        if (sec == SEN_MID_L) f = near21 ? F_NEAR : F_UNIT;
        else if (sec == SEN_CEN_R) f = F_CENTER;
      end
      SEN_CEN_R: begin
        if (sec == SEN_MID_R) f = near34 ? F_NEAR : F_UNIT;
        else if (sec == SEN_CEN_L) f = F_CENTER;
      end
      SEN_MID_R: begin
        if (sec == SEN_CEN_R) f = F_BOOST;
        else if (sec == SEN_OUT_R) f = F_WIDE;
      end
      default: f = F_UNIT;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mts_in_if.sv =====
// Input channel: six inductor readings and the ring flag.
`default_nettype none

interface mts_in_if #(
  parameter int SENSOR_BITS = mts_pkg::SENSOR_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SENSOR_BITS-1:0] sense0;
  logic [SENSOR_BITS-1:0] sense1;
  logic [SENSOR_BITS-1:0] sense2;
  logic [SENSOR_BITS-1:0] sense3;
  logic [SENSOR_BITS-1:0] sense4;
  logic [SENSOR_BITS-1:0] sense5;
  logic                   ring_active;

  modport source (output valid, sense0, sense1, sense2, sense3, sense4, sense5,
                  ring_active, input ready);
  modport sink   (input valid, sense0, sense1, sense2, sense3, sense4, sense5,
                  ring_active, output ready);
endinterface

`default_nettype wire

// ===== rtl/mts_out_if.sv =====
// Result channel: steering command and track-lost flag.
`default_nettype none

interface mts_out_if;
  import mts_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [STEER_W-1:0] steer;
  logic                      track_lost;

  modport source (output valid, steer, track_lost, input ready);
  modport sink   (input valid, steer, track_lost, output ready);
endinterface

`default_nettype wire

// ===== rtl/mts_ctrl.sv =====
// Sequencer: accepts a transaction and steps the datapath through one item.
`default_nettype none

module mts_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  mts_pkg::mts_sts_t  sts,
  output mts_pkg::mts_cmd_t  cmd
);
  import mts_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_GAIN = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // Arithmetic steps overlapped with the sensor scan
  localparam logic [IDX_W-1:0] STEP_NUM  = 3'd0;
  localparam logic [IDX_W-1:0] STEP_RMUL = 3'd1;
  localparam logic [IDX_W-1:0] STEP_FIX  = 3'd2;
  localparam logic [IDX_W-1:0] STEP_PMUL = 3'd3;
  localparam logic [IDX_W-1:0] STEP_PSUM = 3'd4;
  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SENSOR_COUNT - 1);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en  = 1'b1;
        cmd.scan_idx = cnt_r;
        cmd.err_num  = (cnt_r == STEP_NUM);
        cmd.err_mul  = (cnt_r == STEP_RMUL);
        cmd.err_fix  = (cnt_r == STEP_FIX);
        cmd.pd_mul   = (cnt_r == STEP_PMUL);
        cmd.pd_sum   = (cnt_r == STEP_PSUM);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == SCAN_LAST) state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.st_mul = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_mul = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mts_datapath.sv =====
// Datapath: config registers, error, top-two scan, PD, gain, scaling and output register.
`default_nettype none

module mts_datapath #(
  parameter int SENSOR_BITS = mts_pkg::SENSOR_BITS_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  mts_pkg::mts_cmd_t                          cmd,
  output mts_pkg::mts_sts_t                          sts,
  input  wire [mts_pkg::SENSOR_COUNT-1:0][SENSOR_BITS-1:0] in_sense,
  input  wire                                        in_ring,
  input  wire                                        cfg_we,
  input  wire [mts_pkg::CFG_IDX_W-1:0]               cfg_idx,
  input  wire [mts_pkg::CFG_DATA_W-1:0]              cfg_data,
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output logic signed [mts_pkg::STEER_W-1:0]         out_steer,
  output logic                                       out_lost
);
  import mts_pkg::*;

  localparam int B      = SENSOR_BITS;
  localparam int NUM_W  = B + 6;
  localparam int MAG_W  = B + 5;
  localparam int PE_W   = MAG_W + RECIP10_W;
  localparam int Q10_W  = PE_W - RECIP10_SHIFT;
  localparam int QF_W   = Q10_W + 1;
  localparam int PQ_W   = 2 * CAP_W;

  // Configuration registers
  logic [GAIN_W-1:0]  prop_r, deriv_r;
  logic [LIMIT_W-1:0] limit_r, lost_steer_r;
  logic [LEVEL_W-1:0] outer_lvl_r, inner_lost_r, mid_lost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r       <= RST_PROP_GAIN;
      deriv_r      <= RST_DERIV_GAIN;
      limit_r      <= RST_STEER_LIM;
      lost_steer_r <= RST_LOST_STEER;
      outer_lvl_r  <= RST_OUTER_LVL;
      inner_lost_r <= RST_INNER_LOST;
      mid_lost_r   <= RST_MID_LOST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PROP_GAIN:  prop_r       <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_r      <= cfg_data[GAIN_W-1:0];
        REG_STEER_LIM:  limit_r      <= cfg_data[LIMIT_W-1:0];
        REG_LOST_STEER: lost_steer_r <= cfg_data[LIMIT_W-1:0];
        REG_OUTER_LVL:  outer_lvl_r  <= cfg_data[LEVEL_W-1:0];
        REG_INNER_LOST: inner_lost_r <= cfg_data[LEVEL_W-1:0];
        REG_MID_LOST:   mid_lost_r   <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured transaction
  logic [B-1:0] s_r [SENSOR_COUNT];
  logic         ring_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < SENSOR_COUNT; i++) s_r[i] <= in_sense[i];
      ring_r <= in_ring;
    end
  end

  // Error numerator 21*(s1-s4) + 10*(s2-s3), kept as sign and magnitude
  logic signed [B:0]       d14, d23;
  logic signed [NUM_W-1:0] a14, a23, num;
  logic [NUM_W-1:0]        num_abs;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic [PE_W-1:0]         prod_e_r;

  assign d14     = $signed({1'b0, s_r[SEN_MID_L]}) - $signed({1'b0, s_r[SEN_MID_R]});
  assign d23     = $signed({1'b0, s_r[SEN_CEN_L]}) - $signed({1'b0, s_r[SEN_CEN_R]});
  assign a14     = NUM_W'(d14);
  assign a23     = NUM_W'(d23);
  assign num     = (a14 <<< 4) + (a14 <<< 2) + a14 + (a23 <<< 3) + (a23 <<< 1);
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_ff @(posedge clk) begin
    if (cmd.err_num) begin
      mag_r <= num_abs[MAG_W-1:0];
      neg_r <= num[NUM_W-1];
    end
    if (cmd.err_mul) prod_e_r <= PE_W'(mag_r) * PE_W'(RECIP10);
  end

  // Divide by ten with one correction step, then saturate to the error range
  logic [Q10_W-1:0]        q10;
  logic [MAG_W-1:0]        rem10;
  logic [QF_W-1:0]         q10f;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [ERR_W-1:0] err_r;
  logic signed [ERR_W-1:0] prev_err_r;

  assign q10   = prod_e_r[PE_W-1:RECIP10_SHIFT];
  assign rem10 = mag_r - (MAG_W'({q10, 3'b000}) + MAG_W'({q10, 1'b0}));
  assign q10f  = QF_W'(q10) + QF_W'(rem10 >= MAG_W'(TEN));

  always_comb begin
    if (neg_r) begin
      if (q10f > QF_W'(ERR_NEG_MAG)) err_nxt = -ERR_W'(ERR_NEG_MAG);
      else                           err_nxt = ERR_W'(0) - q10f[ERR_W-1:0];
    end else begin
      if (q10f > QF_W'(ERR_POS_MAX)) err_nxt = ERR_W'(ERR_POS_MAX);
      else                           err_nxt = q10f[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_fix) err_r <= err_nxt;
  end

  // PD term
  logic signed [ERR_W:0]    derr;
  logic signed [GAIN_W:0]   pgain, dgain;
  logic signed [PP_W-1:0]   prod_p_r;
  logic signed [PDF_W-1:0]  prod_d_r;
  logic signed [PD_W-1:0]   pd_r;

  assign derr  = {err_r[ERR_W-1], err_r} - {prev_err_r[ERR_W-1], prev_err_r};
  assign pgain = {1'b0, prop_r};
  assign dgain = {1'b0, deriv_r};

  always_ff @(posedge clk) begin
    if (cmd.pd_mul) begin
      prod_p_r <= err_r * pgain;
      prod_d_r <= derr * dgain;
    end
    if (cmd.pd_sum) pd_r <= PD_W'(prod_p_r) + PD_W'(prod_d_r);
  end

  // Top-two scan, one sensor per cycle, lowest index wins ties
  logic [B-1:0]     scan_v;
  logic [B-1:0]     top_v_r, sec_v_r;
  logic [IDX_W-1:0] top_i_r, sec_i_r;
  logic             sec_ok_r;

  assign scan_v = s_r[cmd.scan_idx];

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      if (cmd.scan_idx == SEN_OUT_L) begin
        top_v_r  <= scan_v;
        top_i_r  <= cmd.scan_idx;
        sec_ok_r <= 1'b0;
      end else if (scan_v > top_v_r) begin
        sec_v_r  <= top_v_r;
        sec_i_r  <= top_i_r;
        sec_ok_r <= 1'b1;
        top_v_r  <= scan_v;
        top_i_r  <= cmd.scan_idx;
      end else if (!sec_ok_r || scan_v > sec_v_r) begin
        sec_v_r  <= scan_v;
        sec_i_r  <= cmd.scan_idx;
        sec_ok_r <= 1'b1;
      end
    end
  end

  // Gain product from outer levels and the top-two pattern
  logic [B-1:0]   ol;
  logic           a0, a5, b0, b5, near21, near34;
  logic [B-1:0]   diff21, diff34;
  logic [3:0]     outer_f, pat_f;
  logic [GP_W-1:0] gp_r;

  assign ol     = B'(outer_lvl_r);
  assign a0     = s_r[SEN_OUT_L] > ol;
  assign a5     = s_r[SEN_OUT_R] > ol;
  assign b0     = s_r[SEN_OUT_L] < ol;
  assign b5     = s_r[SEN_OUT_R] < ol;
  assign diff21 = s_r[SEN_CEN_L] - s_r[SEN_MID_L];
  assign diff34 = s_r[SEN_CEN_R] - s_r[SEN_MID_R];
  assign near21 = diff21 < B'(NEAR_MARGIN);
  assign near34 = diff34 < B'(NEAR_MARGIN);
  assign pat_f  = pattern_factor(top_i_r, sec_i_r, near21, near34);

  always_comb begin
    if (a0 || a5)      outer_f = (a0 && a5 && !ring_r) ? F_CUT : F_BOOST;
    else if (b0 && b5) outer_f = F_CUT;
    else               outer_f = F_UNIT;
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) gp_r <= GP_W'(outer_f) * GP_W'(pat_f);
  end

  // Scaled steering value and divide by thousand
  logic signed [GP_W:0]  gp_s;
  logic signed [X_W-1:0] x_r;
  logic [X_W-1:0]        x_abs;
  logic [CAP_W-1:0]      cap_r;
  logic                  x_neg_r;
  logic [PQ_W-1:0]       prod_q_r;

  assign gp_s  = {1'b0, gp_r};
  assign x_abs = x_r[X_W-1] ? X_W'(-x_r) : X_W'(x_r);

  always_ff @(posedge clk) begin
    if (cmd.st_mul) x_r <= pd_r * gp_s;
    if (cmd.div_mul) begin
      x_neg_r  <= x_r[X_W-1];
      cap_r    <= (x_abs > X_W'(CAP_MAX)) ? CAP_MAX : x_abs[CAP_W-1:0];
      prod_q_r <= (x_abs > X_W'(CAP_MAX)) ? PQ_W'(CAP_MAX) * PQ_W'(RECIP1000)
                                          : PQ_W'(x_abs[CAP_W-1:0]) * PQ_W'(RECIP1000);
    end
  end

  // Correction, clamp, lost handling
  logic [LIMIT_W-1:0]        q1k;
  logic [CAP_W-1:0]          rem1k;
  logic [STEER_W-1:0]        q1kf, mag_s;
  logic signed [STEER_W-1:0] steer_calc, steer_nxt;
  logic                      lost_now;

  assign q1k   = prod_q_r[RECIP1000_SHIFT+LIMIT_W-1:RECIP1000_SHIFT];
  assign rem1k = cap_r - CAP_W'(q1k) * CAP_W'(THOUSAND);
  assign q1kf  = STEER_W'(q1k) + STEER_W'(rem1k >= CAP_W'(THOUSAND));
  assign mag_s = (q1kf > STEER_W'(limit_r)) ? STEER_W'(limit_r) : q1kf;
  assign steer_calc = x_neg_r ? -$signed(mag_s) : $signed(mag_s);

  assign lost_now = (s_r[SEN_CEN_L] < B'(inner_lost_r)) && (s_r[SEN_CEN_R] < B'(inner_lost_r))
                 && (s_r[SEN_MID_L] < B'(mid_lost_r))   && (s_r[SEN_MID_R] < B'(mid_lost_r));

  logic [1:0] side_r;

  always_comb begin
    if (lost_now) begin
      case (side_r)
        SIDE_POS: steer_nxt = $signed(STEER_W'(lost_steer_r));
        SIDE_NEG: steer_nxt = -$signed(STEER_W'(lost_steer_r));
        default:  steer_nxt = '0;
      endcase
    end else begin
      steer_nxt = steer_calc;
    end
  end

  // Item state: previous error and remembered side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      side_r     <= SIDE_NONE;
    end else if (cmd.finish) begin
      prev_err_r <= err_r;
      if (!lost_now) side_r <= (!x_neg_r && mag_s != '0) ? SIDE_POS : SIDE_NEG;
    end
  end

  // Output register
  logic                      out_valid_r;
  logic signed [STEER_W-1:0] out_steer_r;
  logic                      out_lost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_steer_r <= steer_nxt;
      out_lost_r  <= lost_now;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_steer    = out_steer_r;
  assign out_lost     = out_lost_r;

endmodule

`default_nettype wire

// ===== rtl/magnetic_track_steering_top.sv =====
// Top level of the magnetic track steering block.
// Each transaction passes through an accept state, a scan state in which
// a single comparator walks the sensors to find the two strongest (the error
// divide and PD multiplies run alongside), then gain, scale multiply,
// divide-by-thousand multiply and a final correct/clamp state that loads the
// result register, waiting there while the previous result is not yet taken;
// the result register lets the next transaction in while the previous result
// still waits on out_bus. Configuration writes take effect on the next edge
// and belong between transactions.
`default_nettype none

module magnetic_track_steering_top #(
  parameter int SENSOR_BITS = mts_pkg::SENSOR_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  mts_in_if.sink                          in_bus,
  mts_out_if.source                       out_bus,
  input  wire                             cfg_we,
  input  wire [mts_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire [mts_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mts_pkg::*;

  mts_cmd_t cmd;
  mts_sts_t sts;
  logic [SENSOR_COUNT-1:0][SENSOR_BITS-1:0] sense_w;

  assign sense_w[SEN_OUT_L] = in_bus.sense0;
  assign sense_w[SEN_MID_L] = in_bus.sense1;
  assign sense_w[SEN_CEN_L] = in_bus.sense2;
  assign sense_w[SEN_CEN_R] = in_bus.sense3;
  assign sense_w[SEN_MID_R] = in_bus.sense4;
  assign sense_w[SEN_OUT_R] = in_bus.sense5;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mts_datapath #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_sense  (sense_w),
    .in_ring   (in_bus.ring_active),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_steer (out_bus.steer),
    .out_lost  (out_bus.track_lost)
  );

endmodule

`default_nettype wire

// ===== rtl/mts_checker.sv =====
// Port-level checker for the steering block, bound to the top level.
`default_nettype none

module mts_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_valid,
  input wire                                 in_ready,
  input wire                                 out_valid,
  input wire                                 out_ready,
  input wire signed [mts_pkg::STEER_W-1:0]   steer,
  input wire                                 track_lost
);

  // One transaction at a time: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // A new result only appears at the end of work, never straight from idle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in progress");

  // A stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(steer) && $stable(track_lost)))
    else $error("result payload changed while stalled");

endmodule

bind magnetic_track_steering_top mts_checker u_mts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .steer      (out_bus.steer),
  .track_lost (out_bus.track_lost)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the magnetic track steering block.
`default_nettype none

module testbench;
  import mts_pkg::*;

  localparam int SENSE_W         = SENSOR_BITS_DEF;
  localparam int SENSE_MAX       = (1 << SENSE_W) - 1;
  localparam int GAP_MAX         = 7;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 30;
  localparam int CFG_ALL_ONES    = (1 << CFG_DATA_W) - 1;
  // No register lives at this index; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                                 ring_active;
    logic [SENSOR_COUNT-1:0][SENSE_W-1:0] sense;
  } reading_t;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer;
    logic                      track_lost;
  } steering_t;

  typedef enum int {PICK_RANDOM, PICK_LOST, PICK_EDGE, PICK_TIES, PICK_PEAK} pick_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mts_in_if #(.SENSOR_BITS(SENSE_W)) in_bus ();
  mts_out_if out_bus ();

  magnetic_track_steering_top #(.SENSOR_BITS(SENSE_W)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Register copies and steering state of the predictor
  int prop_tenths  = int'(RST_PROP_GAIN);
  int deriv_tenths = int'(RST_DERIV_GAIN);
  int steer_lim    = int'(RST_STEER_LIM);
  int lost_mag     = int'(RST_LOST_STEER);
  int outer_lvl    = int'(RST_OUTER_LVL);
  int inner_lvl    = int'(RST_INNER_LOST);
  int mid_lvl      = int'(RST_MID_LOST);
  int prev_err     = 0;
  int side         = 0;

  reading_t  pending_readings[$];
  steering_t expected_steering[$];
  reading_t  feed_item = '0;

  int feed_gap = 0;
  int feed_gap_max = 0;
  int take_gap = 0;
  int take_gap_max = 0;
  int error_count = 0;
  int cycle_count = 0;
  // Readings put on the bus versus readings accepted by the block
  int sent_count = 0;
  int accepted_count = 0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit hold_go = 1'b0;
  bit hold_ready = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Steering predictor: one result per reading, updates error and side state
  function automatic steering_t predict_steering(input reading_t r);
    int s[SENSOR_COUNT];
    int err, top_v, sec_v, top_i, sec_i, outer, pat;
    bit above_l, above_r, lost;
    longint pd, cmd;
    steering_t res;
    for (int i = 0; i < SENSOR_COUNT; i++) s[i] = int'(r.sense[i]);

    err = (21 * (s[SEN_MID_L] - s[SEN_MID_R]) + 10 * (s[SEN_CEN_L] - s[SEN_CEN_R])) / 10;
    if (err > ERR_POS_MAX) err = ERR_POS_MAX;
    if (err < -ERR_NEG_MAG) err = -ERR_NEG_MAG;

    // Two strongest sensors, lowest index wins a tie
    top_v = -1; sec_v = -1; top_i = 1; sec_i = 1;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (s[i] > top_v) begin
        sec_v = top_v; sec_i = top_i;
        top_v = s[i];  top_i = i;
      end else if (s[i] > sec_v) begin
        sec_v = s[i]; sec_i = i;
      end
    end

    // Outer sensor factor
    above_l = s[SEN_OUT_L] > outer_lvl;
    above_r = s[SEN_OUT_R] > outer_lvl;
    if (above_l || above_r)
      outer = (above_l && above_r && !r.ring_active) ? int'(F_CUT) : int'(F_BOOST);
    else if (s[SEN_OUT_L] < outer_lvl && s[SEN_OUT_R] < outer_lvl)
      outer = int'(F_CUT);
    else
      outer = int'(F_UNIT);

    // Factor from the top-two pair
    pat = int'(F_UNIT);
    if (top_i == SEN_MID_L && sec_i == SEN_CEN_L) pat = int'(F_BOOST);
    if (top_i == SEN_MID_L && sec_i == SEN_OUT_L) pat = int'(F_WIDE);
    if (top_i == SEN_CEN_L && sec_i == SEN_MID_L)
      pat = (s[SEN_CEN_L] - s[SEN_MID_L] < NEAR_MARGIN) ? int'(F_NEAR) : int'(F_UNIT);
    if (top_i == SEN_CEN_R && sec_i == SEN_MID_R)
      pat = (s[SEN_CEN_R] - s[SEN_MID_R] < NEAR_MARGIN) ? int'(F_NEAR) : int'(F_UNIT);
    if ((top_i == SEN_CEN_L && sec_i == SEN_CEN_R) ||
        (top_i == SEN_CEN_R && sec_i == SEN_CEN_L)) pat = int'(F_CENTER);
    if (top_i == SEN_MID_R && sec_i == SEN_CEN_R) pat = int'(F_BOOST);
    if (top_i == SEN_MID_R && sec_i == SEN_OUT_R) pat = int'(F_WIDE);

    pd  = longint'(err) * prop_tenths + longint'(err - prev_err) * deriv_tenths;
    cmd = longint'(outer * pat) * pd / THOUSAND;
    if (cmd > steer_lim) cmd = steer_lim;
    if (cmd < -steer_lim) cmd = -steer_lim;

    lost = s[SEN_CEN_L] < inner_lvl && s[SEN_CEN_R] < inner_lvl &&
           s[SEN_MID_L] < mid_lvl && s[SEN_MID_R] < mid_lvl;
    if (lost) cmd = longint'(side) * lost_mag;
    else side = (cmd > 0) ? 1 : -1;
    prev_err = err;

    res.steer      = cmd[STEER_W-1:0];
    res.track_lost = lost;
    return res;
  endfunction

  function automatic reading_t reading(input int s0, input int s1, input int s2,
                                       input int s3, input int s4, input int s5,
                                       input bit ring);
    reading_t r;
    r.sense = {s5[SENSE_W-1:0], s4[SENSE_W-1:0], s3[SENSE_W-1:0],
               s2[SENSE_W-1:0], s1[SENSE_W-1:0], s0[SENSE_W-1:0]};
    r.ring_active = ring;
    return r;
  endfunction

  function automatic int clamp_sense(input int v);
    return (v < 0) ? 0 : (v > SENSE_MAX) ? SENSE_MAX : v;
  endfunction

  // A reading strictly below a level where one exists
  function automatic int below(input int lvl);
    return (lvl == 0) ? 0 : int'($urandom_range(0, lvl - 1));
  endfunction

  // A reading within one count of a level
  function automatic int around(input int lvl);
    return clamp_sense(lvl + int'($urandom_range(0, 2)) - 1);
  endfunction

  // Random readings shaped to hit lost tracking, level edges, ties and peaks
  function automatic reading_t random_reading();
    reading_t r;
    pick_t pick;
    int v, w, t, u;
    pick = pick_t'($urandom_range(0, 4));
    r.ring_active = 1'($urandom_range(0, 1));
    for (int i = 0; i < SENSOR_COUNT; i++)
      r.sense[i] = SENSE_W'($urandom_range(0, SENSE_MAX));
    case (pick)
      PICK_LOST: begin
        r.sense[SEN_MID_L] = SENSE_W'(below(mid_lvl));
        r.sense[SEN_MID_R] = SENSE_W'(below(mid_lvl));
        r.sense[SEN_CEN_L] = SENSE_W'(below(inner_lvl));
        r.sense[SEN_CEN_R] = SENSE_W'(below(inner_lvl));
      end
      PICK_EDGE: begin
        r.sense[SEN_OUT_L] = SENSE_W'(around(outer_lvl));
        r.sense[SEN_OUT_R] = SENSE_W'(around(outer_lvl));
        r.sense[SEN_MID_L] = SENSE_W'(around(mid_lvl));
        r.sense[SEN_MID_R] = SENSE_W'(around(mid_lvl));
        r.sense[SEN_CEN_L] = SENSE_W'(around(inner_lvl));
        r.sense[SEN_CEN_R] = SENSE_W'(around(inner_lvl));
      end
      PICK_TIES: begin
        v = $urandom_range(0, SENSE_MAX);
        for (int i = 0; i < SENSOR_COUNT; i++)
          if ($urandom_range(0, 1)) r.sense[i] = SENSE_W'(v);
      end
      PICK_PEAK: begin
        t = $urandom_range(0, SENSOR_COUNT - 1);
        if (t == 0) u = 1;
        else if (t == SENSOR_COUNT - 1) u = t - 1;
        else u = $urandom_range(0, 1) ? t - 1 : t + 1;
        v = $urandom_range(40, SENSE_MAX);
        w = v - int'($urandom_range(0, 2 * NEAR_MARGIN));
        for (int i = 0; i < SENSOR_COUNT; i++) r.sense[i] = SENSE_W'($urandom_range(0, w));
        r.sense[t] = SENSE_W'(v);
        r.sense[u] = SENSE_W'(w);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Reading driver: offers queued readings with a random gap before each
  always @(negedge clk) begin
    logic nv;
    nv = in_bus.valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      nv = 1'b0;
      if (feed_gap != 0) begin
        feed_gap = feed_gap - 1;
      end else if (pending_readings.size() != 0) begin
        feed_item = pending_readings.pop_front();
        sent_count++;
        nv = 1'b1;
        feed_gap = $urandom_range(0, feed_gap_max);
      end
    end
    in_bus.valid       <= nv;
    in_bus.sense0      <= feed_item.sense[0];
    in_bus.sense1      <= feed_item.sense[1];
    in_bus.sense2      <= feed_item.sense[2];
    in_bus.sense3      <= feed_item.sense[3];
    in_bus.sense4      <= feed_item.sense[4];
    in_bus.sense5      <= feed_item.sense[5];
    in_bus.ring_active <= feed_item.ring_active;
  end

  // Result sink: random stall after each taken result, plus the long hold-off
  always @(negedge clk) begin
    logic nr;
    nr = 1'b0;
    if (rst_n) begin
      if (out_taken) take_gap = $urandom_range(0, take_gap_max);
      if (hold_ready) begin
        nr = 1'b0;
      end else if (take_gap != 0) begin
        take_gap = take_gap - 1;
      end else begin
        nr = 1'b1;
      end
    end
    out_bus.ready <= nr;
  end

  // Long receiver hold-off, counted here while the driver keeps offering
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_ready = 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    hold_ready = 1'b0;
  end

  // Monitor: predict on accepted readings, check accepted results
  always @(posedge clk) begin
    reading_t seen;
    steering_t want;
    in_taken  = rst_n && in_bus.valid && in_bus.ready;
    out_taken = rst_n && out_bus.valid && out_bus.ready;
    if (out_taken) begin
      if (expected_steering.size() == 0) begin
        $error("unexpected result: steer %0d track_lost %0d",
               out_bus.steer, out_bus.track_lost);
        error_count++;
      end else begin
        want = expected_steering.pop_front();
        if (out_bus.steer !== want.steer) begin
          $error("steer: expected %0d, actual %0d", want.steer, out_bus.steer);
          error_count++;
        end
        if (out_bus.track_lost !== want.track_lost) begin
          $error("track_lost: expected %0d, actual %0d",
                 want.track_lost, out_bus.track_lost);
          error_count++;
        end
      end
    end
    if (in_taken) begin
      seen = reading(int'(in_bus.sense0), int'(in_bus.sense1), int'(in_bus.sense2),
                     int'(in_bus.sense3), int'(in_bus.sense4), int'(in_bus.sense5),
                     in_bus.ring_active);
      expected_steering.push_back(predict_steering(seen));
      accepted_count++;
    end
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Register write; the predictor copy follows the same masking
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    case (idx)
      REG_PROP_GAIN:  prop_tenths  = value & ((1 << GAIN_W) - 1);
      REG_DERIV_GAIN: deriv_tenths = value & ((1 << GAIN_W) - 1);
      REG_STEER_LIM:  steer_lim    = value & ((1 << LIMIT_W) - 1);
      REG_LOST_STEER: lost_mag     = value & ((1 << LIMIT_W) - 1);
      REG_OUTER_LVL:  outer_lvl    = value & ((1 << LEVEL_W) - 1);
      REG_INNER_LOST: inner_lvl    = value & ((1 << LEVEL_W) - 1);
      REG_MID_LOST:   mid_lvl      = value & ((1 << LEVEL_W) - 1);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input int p, input int d, input int lim, input int lmag,
                            input int ol, input int il, input int ml);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_STEER_LIM, lim);
    write_reg(REG_LOST_STEER, lmag);
    write_reg(REG_OUTER_LVL, ol);
    write_reg(REG_INNER_LOST, il);
    write_reg(REG_MID_LOST, ml);
  endtask

  // Wait until every queued reading is in and every result has come back
  task automatic wait_idle();
    while (pending_readings.size() != 0 || sent_count != accepted_count ||
           expected_steering.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic run_random(input int count, input int src_max, input int snk_max);
    feed_gap_max = src_max;
    take_gap_max = snk_max;
    repeat (count) pending_readings.push_back(random_reading());
    wait_idle();
  endtask

  // Stimulus sequence
  initial begin
    in_bus.valid       = 1'b0;
    in_bus.sense0      = '0;
    in_bus.sense1      = '0;
    in_bus.sense2      = '0;
    in_bus.sense3      = '0;
    in_bus.sense4      = '0;
    in_bus.sense5      = '0;
    in_bus.ring_active = 1'b0;
    out_bus.ready      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed readings under reset register values
    feed_gap_max = 3;
    take_gap_max = 3;
    // lost before any side is known
    pending_readings.push_back(reading(0, 0, 0, 0, 0, 0, 1'b0));
    // zero steer while tracking picks the negative side
    pending_readings.push_back(reading(255, 255, 255, 255, 255, 255, 1'b1));
    pending_readings.push_back(reading(0, 0, 0, 0, 0, 0, 1'b1));
    pending_readings.push_back(reading(0, 255, 0, 0, 0, 0, 1'b0));
    pending_readings.push_back(reading(0, 0, 0, 0, 255, 0, 1'b0));
    // each top-two pair
    pending_readings.push_back(reading(10, 200, 180, 20, 20, 10, 1'b0));
    pending_readings.push_back(reading(10, 190, 200, 20, 20, 10, 1'b0));
    pending_readings.push_back(reading(10, 100, 200, 20, 20, 10, 1'b0));
    pending_readings.push_back(reading(10, 185, 200, 20, 20, 10, 1'b0));
    pending_readings.push_back(reading(10, 20, 200, 199, 20, 10, 1'b0));
    pending_readings.push_back(reading(10, 20, 150, 200, 20, 10, 1'b0));
    pending_readings.push_back(reading(10, 20, 20, 200, 190, 10, 1'b0));
    pending_readings.push_back(reading(10, 20, 20, 200, 186, 10, 1'b0));
    pending_readings.push_back(reading(10, 20, 20, 180, 200, 10, 1'b0));
    pending_readings.push_back(reading(10, 20, 20, 20, 200, 180, 1'b0));
    // outer sensor cases: both above with and without ring, one above,
    // one at the level, both below
    pending_readings.push_back(reading(255, 20, 20, 20, 20, 250, 1'b0));
    pending_readings.push_back(reading(255, 20, 20, 20, 20, 250, 1'b1));
    pending_readings.push_back(reading(51, 100, 40, 40, 100, 10, 1'b0));
    pending_readings.push_back(reading(50, 100, 40, 40, 80, 10, 1'b0));
    pending_readings.push_back(reading(49, 200, 40, 40, 10, 49, 1'b0));
    // largest error of each sign
    pending_readings.push_back(reading(0, 255, 255, 0, 0, 0, 1'b0));
    pending_readings.push_back(reading(0, 0, 0, 255, 255, 0, 1'b1));
    // lost-level boundaries
    pending_readings.push_back(reading(0, 59, 29, 29, 59, 0, 1'b0));
    pending_readings.push_back(reading(0, 59, 30, 29, 59, 0, 1'b0));
    pending_readings.push_back(reading(255, 255, 255, 255, 255, 255, 1'b0));
    wait_idle();

    run_random(150, GAP_MAX, GAP_MAX);

    // All registers at their top, then a write to the unused index
    set_config(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES,
               CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
    write_reg(REG_UNUSED, 0);
    run_random(100, 0, 0);

    // All registers at zero
    set_config(0, 0, 0, 0, 0, 0, 0);
    run_random(80, GAP_MAX, 0);

    // Random register settings
    repeat (3) begin
      set_config($urandom_range(0, CFG_ALL_ONES), $urandom_range(0, CFG_ALL_ONES),
                 $urandom_range(0, CFG_ALL_ONES), $urandom_range(0, CFG_ALL_ONES),
                 $urandom_range(0, CFG_ALL_ONES), $urandom_range(0, CFG_ALL_ONES),
                 $urandom_range(0, CFG_ALL_ONES));
      run_random(80, $urandom_range(0, GAP_MAX), GAP_MAX);
    end

    // Back-pressure: the sink holds off while readings keep coming
    set_config(int'(RST_PROP_GAIN), int'(RST_DERIV_GAIN), int'(RST_STEER_LIM),
               int'(RST_LOST_STEER), int'(RST_OUTER_LVL), int'(RST_INNER_LOST),
               int'(RST_MID_LOST));
    hold_go = 1'b1;
    run_random(60, 0, 2);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
